// File: sv/csmacd_pkg.sv
package csmacd_pkg;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JAM_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JAM_CODE    = 3'd4;

  localparam logic [7:0]  RST_JAM_TICKS   = 8'd4;
  localparam logic [3:0]  RST_RETRY_LIMIT = 4'd15;
  localparam logic [12:0] RST_SLOT_TICKS  = 13'd64;
  localparam logic [7:0]  RST_EMPTY_CODE  = 8'd0;
  localparam logic [7:0]  RST_JAM_CODE    = 8'd35;

  localparam logic [4:0]  BACKOFF_EXP_CAP = 5'd10;
  localparam logic [15:0] SENT_MAX        = 16'hFFFF;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic [7:0]  jam_ticks;
    logic [3:0]  retry_limit;
    logic [12:0] slot_ticks;
    logic [7:0]  empty_code;
    logic [7:0]  jam_code;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  random_bits;
    logic [15:0] msg_size;
    logic [7:0]  msg_symbol;
    logic        msg_valid;
    logic [7:0]  cable_symbol;
  } item_t;

  typedef struct packed {
    logic        message_abandoned;
    logic        message_done;
    logic        message_taken;
    logic        collision;
    logic [7:0]  drive_symbol;
    logic        drive;
  } result_t;

  typedef struct packed {
    logic        active;
    logic        transmitting;
    logic [7:0]  held_symbol;
    logic [15:0] held_size;
    logic [15:0] sent_count;
    logic [4:0]  retry_count;
    logic [7:0]  jam_left;
    logic [22:0] backoff_left;
  } state_t;

endpackage

// File: sv/csmacd_cfg.sv
module csmacd_cfg import csmacd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jam_ticks   <= RST_JAM_TICKS;
      cfg.retry_limit <= RST_RETRY_LIMIT;
      cfg.slot_ticks  <= RST_SLOT_TICKS;
      cfg.empty_code  <= RST_EMPTY_CODE;
      cfg.jam_code    <= RST_JAM_CODE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_JAM_TICKS:   cfg.jam_ticks   <= wr_data[7:0];
        REG_RETRY_LIMIT: cfg.retry_limit <= wr_data[3:0];
        REG_SLOT_TICKS:  cfg.slot_ticks  <= wr_data[12:0];
        REG_EMPTY_CODE:  cfg.empty_code  <= wr_data[7:0];
        REG_JAM_CODE:    cfg.jam_code    <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/csmacd_core.sv
module csmacd_core import csmacd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  state_t st, st_next;

  always_comb begin
    logic [7:0]  jl;
    logic [4:0]  rtry;
    logic [4:0]  e;
    logic [9:0]  k;
    logic [15:0] sent_inc;
    st_next  = st;
    res      = '0;
    jl       = st.jam_left - 8'd1;
    rtry     = st.retry_count + 5'd1;
    e        = (rtry < BACKOFF_EXP_CAP) ? rtry : BACKOFF_EXP_CAP;
    k        = item.random_bits & ~(10'h3FF << e);
    sent_inc = '0;
    if (st.jam_left != 8'd0) begin
      res.drive        = 1'b1;
      res.drive_symbol = cfg.jam_code;
      st_next.jam_left = jl;
      if (jl == 8'd0) begin
        st_next.transmitting = 1'b0;
        st_next.sent_count   = '0;
        if (rtry > {1'b0, cfg.retry_limit}) begin
          st_next.retry_count   = '0;
          st_next.active        = 1'b0;
          res.message_abandoned = 1'b1;
        end else begin
          st_next.retry_count  = rtry;
          st_next.backoff_left = {13'd0, k} * {10'd0, cfg.slot_ticks};
        end
      end
    end else if (st.backoff_left != 23'd0) begin
      st_next.backoff_left = st.backoff_left - 23'd1;
    end else begin
      if (!st.active && item.msg_valid) begin
        st_next.active      = 1'b1;
        st_next.held_symbol = item.msg_symbol;
        st_next.held_size   = item.msg_size;
        st_next.sent_count  = '0;
        st_next.retry_count = '0;
        res.message_taken   = 1'b1;
      end
      sent_inc = (st_next.sent_count < SENT_MAX) ? st_next.sent_count + 16'd1
                                                 : st_next.sent_count;
      if (!st_next.active) begin
        st_next.transmitting = 1'b0;
      end else if (st_next.transmitting && st_next.sent_count != 16'd0 &&
                   item.cable_symbol != cfg.empty_code &&
                   item.cable_symbol != st_next.held_symbol) begin
        st_next.transmitting = 1'b0;
        res.collision        = 1'b1;
        res.drive            = 1'b1;
        res.drive_symbol     = cfg.jam_code;
        st_next.jam_left     = (cfg.jam_ticks != 8'd0) ? cfg.jam_ticks - 8'd1 : 8'd0;
      end else if (item.cable_symbol == cfg.empty_code ||
                   item.cable_symbol == st_next.held_symbol) begin
        res.drive            = 1'b1;
        res.drive_symbol     = st_next.held_symbol;
        st_next.transmitting = 1'b1;
        st_next.sent_count   = sent_inc;
        if (sent_inc >= st_next.held_size) begin
          res.message_done     = 1'b1;
          st_next.transmitting = 1'b0;
          st_next.sent_count   = '0;
          st_next.retry_count  = '0;
          st_next.active       = 1'b0;
        end
      end else begin
        // foreign traffic before the first driven tick: wait quietly
        st_next.transmitting = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

// File: sv/csma_cd_station_transmitter_unit.sv
// CSMA/CD station transmitter with binary exponential backoff.
// Each slave-side transaction is one cable tick: the symbol seen at the tap,
// an offered message (flag, symbol, size) and ten random bits. Each tick
// yields exactly one master-side transaction with the drive decision and
// the collision, taken, done and abandoned flags.
// From slave acceptance a tick passes the input register, then the tick
// logic and station state update feeding the output register, to m_tdata.
// Throughput is one tick per cycle while the receiver does not stall.
// While the receiver stalls, a held result keeps m_tvalid high and one more
// tick may wait in the input register; s_tready drops only when both are
// full. Configuration is written through wr_en/wr_index/wr_data while the
// block is idle; the user must keep to that, the block does not enforce it.
// Writes to unused indexes are ignored.
// Synchronous reset clears the station state, the pipeline valids and puts
// the registers to their defaults (jam 4, retries 15, slot 64, empty 0,
// jam code 35).
module csma_cd_station_transmitter_unit import csmacd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // cable_symbol[7:0], msg_valid[8], msg_symbol[16:9], msg_size[32:17],
  // random_bits[42:33], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // drive[0], drive_symbol[8:1], collision[9], message_taken[10],
  // message_done[11], message_abandoned[12], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t core_res;
  result_t out_res;
  logic    out_valid;
  logic    advance;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  csmacd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  csmacd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (in_valid && advance),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[$bits(item_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_res};

  a_idle_symbol_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.drive) |-> (out_res.drive_symbol == 8'd0))
    else $error("drive_symbol nonzero while not driving");

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({out_res.collision, out_res.message_done,
                           out_res.message_abandoned}))
    else $error("collision, done and abandoned overlap");

  a_collision_drives: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.collision) |-> (out_res.drive && !out_res.message_taken))
    else $error("collision without jam drive");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && in_valid))
    else $error("input stalled while pipeline has room");

endmodule
